### sv/tffs_pkg.sv
package tffs_pkg;

  // FNV-1a 32-bit constants.
  localparam logic [31:0] FNV_BASIS = 32'd2166136261;
  localparam logic [31:0] FNV_PRIME = 32'd16777619;

  // Stream header words; the second one holds four ASCII letters, lowest byte first.
  localparam logic [31:0] MAGIC_WORD0 = 32'h0100_0000;
  localparam logic [31:0] MAGIC_WORD1 = 32'h5550_4756;

  localparam int unsigned HEIGHT_LIMIT = 4096;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 13;
  localparam int unsigned DIM_W      = 13;

  // Result event queue between the hash stage and the output port.
  localparam int unsigned EVQ_DEPTH = 4;
  localparam int unsigned EVQ_AW    = $clog2(EVQ_DEPTH);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1,
    REG_PIXEL_FORMAT = 2'd2
  } cfg_reg_e;

  typedef enum logic [1:0] {
    KIND_MAGIC = 2'd0,
    KIND_DIM   = 2'd1,
    KIND_TILE  = 2'd2
  } word_kind_e;

  // Position of a word within the results of one byte.
  typedef enum logic [2:0] {
    SLOT_MAGIC0 = 3'd0,
    SLOT_MAGIC1 = 3'd1,
    SLOT_WIDTH  = 3'd2,
    SLOT_HEIGHT = 3'd3,
    SLOT_TILE   = 3'd4
  } slot_e;

  // One queued event: the header, a tile hash, or both.
  typedef struct packed {
    logic        hdr;
    logic        emit;
    logic        done;
    logic [31:0] hash;
  } ev_t;

endpackage

### sv/tffs_ram.sv
module tffs_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Read returns the old contents when the same entry is written in that cycle.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### sv/tiled_frame_fnv_signature_core.sv
// Tiled frame signature core. Frame bytes stream in one per transfer in raster
// order, with no row padding: rows of width*4 bytes for the packed format, or
// width bytes for planar 4:2:0 with the chroma rows following the luma rows.
// The frame is split into TILE_SIZE x TILE_SIZE pixel tiles, and each tile is
// hashed with 32-bit FNV-1a over its bytes in raster order. The first byte of
// a frame produces a four-word header (two magic words, then the effective
// width and height), and each tile hash is sent as soon as the last byte of
// its tile arrives; the final hash of the frame carries frame_done. Width and
// height are saturated to [1, MAX_WIDTH] and [1, 4096]. The core accepts one
// byte per clock cycle unless input is held off. Each byte reads its tile-column
// accumulator from a synchronous RAM, is folded in the next cycle and written
// back, and a register holding the last written accumulator forwards it to the
// next byte of the same column, so the read-modify-write loop never stalls input.
// Results pass through a four-entry event queue; input is held off only while
// that queue, plus the byte being hashed, is full, which happens when the
// output side stalls or when bytes that each cause several words arrive faster
// than the words drain, as with a run of very small frames.
// A configuration write restarts the frame and must only be issued while the
// core is idle.
module tiled_frame_fnv_signature_core #(
  parameter int unsigned MAX_WIDTH = 4096,
  parameter int unsigned TILE_SIZE = 64
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Configuration write channel.
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [tffs_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [tffs_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // Input byte channel.
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [7:0]                      pixel_byte_i,
  // Output word channel.
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [31:0]                     out_word_o,
  output logic [1:0]                      word_kind_o,
  output logic                            frame_done_o
);

  import tffs_pkg::*;

  localparam int unsigned TILE_COLS = (MAX_WIDTH + TILE_SIZE - 1) / TILE_SIZE;
  localparam int unsigned CW  = (TILE_COLS > 1) ? $clog2(TILE_COLS) : 1;
  localparam int unsigned XW  = $clog2(TILE_SIZE);
  localparam int unsigned PCW = $clog2(MAX_WIDTH);
  localparam int unsigned WW  = $clog2(MAX_WIDTH + 1);

  // Configuration registers.
  logic [DIM_W-1:0] frame_width_q, frame_width_d;
  logic [DIM_W-1:0] frame_height_q, frame_height_d;
  logic             pixel_format_q, pixel_format_d;

  // Stream position.
  logic [1:0]       bip_q, bip_d;
  logic [PCW-1:0]   pix_col_q, pix_col_d;
  logic [XW-1:0]    x_tile_q, x_tile_d;
  logic [CW-1:0]    tile_col_q, tile_col_d;
  logic [DIM_W-1:0] row_q, row_d;
  logic [XW-1:0]    band_row_q, band_row_d;
  logic             started_q, started_d;

  // Hash stage.
  logic             b_valid_q;
  logic [7:0]       b_byte_q;
  logic [CW-1:0]    b_col_q;
  logic             b_seed_q, b_hdr_q, b_emit_q, b_done_q;

  // Last accumulator written back, used for forwarding.
  logic             last_vld_q;
  logic [CW-1:0]    last_col_q;
  logic [31:0]      last_acc_q;

  // Event queue.
  ev_t              evq_q [EVQ_DEPTH];
  logic [EVQ_AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [EVQ_AW:0]  cnt_q, cnt_d;
  logic [2:0]       hdr_pos_q, hdr_pos_d;

  logic             cfg_acc, in_acc, out_acc;
  logic             cfg_restart;
  logic [WW-1:0]    eff_w;
  logic [DIM_W-1:0] eff_h, rows;
  logic             last_byte, col_last, row_last, x_last, band_last;
  logic             seed, emit, done;
  logic [31:0]      ram_rdata, operand, acc;
  logic             push, pop;
  ev_t              head, ev_new;
  logic [2:0]       slot;
  logic             last_word;

  assign cfg_ready_o = 1'b1;
  assign cfg_acc     = cfg_valid_i & cfg_ready_o;
  assign in_acc      = in_valid_i & in_ready_o;
  assign out_acc     = out_valid_o & out_ready_i;

  // Room for the byte in the hash stage and one more accepted now.
  assign in_ready_o = ({1'b0, cnt_q} + (EVQ_AW + 2)'(b_valid_q)) < (EVQ_AW + 2)'(EVQ_DEPTH);

  // Effective geometry.
  always_comb begin
    if (frame_width_q == '0) begin
      eff_w = WW'(1);
    end else if (32'(frame_width_q) > 32'(MAX_WIDTH)) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = WW'(frame_width_q);
    end
    if (frame_height_q == '0) begin
      eff_h = DIM_W'(1);
    end else if (32'(frame_height_q) > 32'(HEIGHT_LIMIT)) begin
      eff_h = DIM_W'(HEIGHT_LIMIT);
    end else begin
      eff_h = frame_height_q;
    end
    if (pixel_format_q) begin
      rows = DIM_W'((14'(eff_h) + ((14'(eff_h) + 14'd1) >> 1)));
    end else begin
      rows = eff_h;
    end
  end

  assign last_byte = pixel_format_q | (bip_q == 2'd3);
  assign col_last  = (pix_col_q == PCW'(eff_w - WW'(1)));
  assign row_last  = (row_q == (rows - DIM_W'(1)));
  assign x_last    = (x_tile_q == XW'(TILE_SIZE - 1));
  assign band_last = (band_row_q == XW'(TILE_SIZE - 1));

  assign seed = (band_row_q == '0) & (x_tile_q == '0) & (bip_q == 2'd0);
  assign emit = last_byte & (x_last | col_last) & (band_last | row_last);
  assign done = col_last & row_last;

  // Configuration writes; an unknown index is ignored and keeps the frame.
  always_comb begin
    frame_width_d  = frame_width_q;
    frame_height_d = frame_height_q;
    pixel_format_d = pixel_format_q;
    cfg_restart    = 1'b0;
    if (cfg_acc) begin
      unique case (cfg_index_i)
        REG_FRAME_WIDTH: begin
          frame_width_d = cfg_data_i;
          cfg_restart   = 1'b1;
        end
        REG_FRAME_HEIGHT: begin
          frame_height_d = cfg_data_i;
          cfg_restart    = 1'b1;
        end
        REG_PIXEL_FORMAT: begin
          pixel_format_d = cfg_data_i[0];
          cfg_restart    = 1'b1;
        end
        default: begin
          cfg_restart = 1'b0;
        end
      endcase
    end
  end

  // Stream position update for each accepted byte.
  always_comb begin
    bip_d      = bip_q;
    pix_col_d  = pix_col_q;
    x_tile_d   = x_tile_q;
    tile_col_d = tile_col_q;
    row_d      = row_q;
    band_row_d = band_row_q;
    started_d  = started_q;
    if (cfg_restart) begin
      bip_d      = '0;
      pix_col_d  = '0;
      x_tile_d   = '0;
      tile_col_d = '0;
      row_d      = '0;
      band_row_d = '0;
      started_d  = 1'b0;
    end else if (in_acc) begin
      started_d = 1'b1;
      if (last_byte) begin
        bip_d = '0;
        if (col_last) begin
          pix_col_d  = '0;
          x_tile_d   = '0;
          tile_col_d = '0;
          if (row_last) begin
            row_d      = '0;
            band_row_d = '0;
            started_d  = 1'b0;
          end else begin
            row_d      = row_q + DIM_W'(1);
            band_row_d = band_last ? '0 : band_row_q + XW'(1);
          end
        end else begin
          pix_col_d = pix_col_q + PCW'(1);
          x_tile_d  = x_last ? '0 : x_tile_q + XW'(1);
          if (x_last) begin
            tile_col_d = tile_col_q + CW'(1);
          end
        end
      end else begin
        bip_d = bip_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= DIM_W'(64);
      frame_height_q <= DIM_W'(64);
      pixel_format_q <= 1'b0;
      bip_q          <= '0;
      pix_col_q      <= '0;
      x_tile_q       <= '0;
      tile_col_q     <= '0;
      row_q          <= '0;
      band_row_q     <= '0;
      started_q      <= 1'b0;
      b_valid_q      <= 1'b0;
      last_vld_q     <= 1'b0;
      last_acc_q     <= '0;
    end else begin
      frame_width_q  <= frame_width_d;
      frame_height_q <= frame_height_d;
      pixel_format_q <= pixel_format_d;
      bip_q          <= bip_d;
      pix_col_q      <= pix_col_d;
      x_tile_q       <= x_tile_d;
      tile_col_q     <= tile_col_d;
      row_q          <= row_d;
      band_row_q     <= band_row_d;
      started_q      <= started_d;
      b_valid_q      <= in_acc;
      if (b_valid_q) begin
        last_vld_q <= 1'b1;
        last_acc_q <= acc;
      end
    end
  end

  // Hash stage payload.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      b_byte_q <= pixel_byte_i;
      b_col_q  <= tile_col_q;
      b_seed_q <= seed;
      b_hdr_q  <= ~started_q;
      b_emit_q <= emit;
      b_done_q <= done;
    end
    if (b_valid_q) begin
      last_col_q <= b_col_q;
    end
  end

  // Tile-column accumulators. The read is issued with the byte's transfer.
  tffs_ram #(
    .WIDTH (32),
    .DEPTH (TILE_COLS),
    .AW    (CW)
  ) u_acc_ram (
    .clk_i   (clk_i),
    .we_i    (b_valid_q),
    .waddr_i (b_col_q),
    .wdata_i (acc),
    .raddr_i (tile_col_q),
    .rdata_o (ram_rdata)
  );

  // The RAM misses a write made on the same edge as the read, so the most
  // recent accumulator comes from the forwarding register instead.
  always_comb begin
    priority if (b_seed_q) begin
      operand = FNV_BASIS;
    end else if (last_vld_q && (last_col_q == b_col_q)) begin
      operand = last_acc_q;
    end else begin
      operand = ram_rdata;
    end
    acc = 32'((operand ^ {24'd0, b_byte_q}) * FNV_PRIME);
  end

  // Event queue.
  assign push = b_valid_q & (b_hdr_q | b_emit_q);
  assign ev_new = '{hdr: b_hdr_q, emit: b_emit_q, done: b_done_q, hash: acc};

  always_ff @(posedge clk_i) begin
    if (push) begin
      evq_q[wr_ptr_q] <= ev_new;
    end
  end

  assign head      = evq_q[rd_ptr_q];
  assign slot      = head.hdr ? hdr_pos_q : SLOT_TILE;
  assign last_word = (slot == SLOT_TILE) || ((slot == SLOT_HEIGHT) && !head.emit);
  assign pop       = out_acc & last_word;

  always_comb begin
    cnt_d = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + (EVQ_AW + 1)'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - (EVQ_AW + 1)'(1);
    end
    hdr_pos_d = hdr_pos_q;
    if (pop) begin
      hdr_pos_d = '0;
    end else if (out_acc) begin
      hdr_pos_d = hdr_pos_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q  <= '0;
      rd_ptr_q  <= '0;
      cnt_q     <= '0;
      hdr_pos_q <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + EVQ_AW'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + EVQ_AW'(1);
      end
      cnt_q     <= cnt_d;
      hdr_pos_q <= hdr_pos_d;
    end
  end

  // Output word selection.
  assign out_valid_o = (cnt_q != '0);

  always_comb begin
    unique case (slot)
      SLOT_MAGIC0: begin
        out_word_o  = MAGIC_WORD0;
        word_kind_o = KIND_MAGIC;
      end
      SLOT_MAGIC1: begin
        out_word_o  = MAGIC_WORD1;
        word_kind_o = KIND_MAGIC;
      end
      SLOT_WIDTH: begin
        out_word_o  = 32'(eff_w);
        word_kind_o = KIND_DIM;
      end
      SLOT_HEIGHT: begin
        out_word_o  = 32'(eff_h);
        word_kind_o = KIND_DIM;
      end
      default: begin
        out_word_o  = head.hash;
        word_kind_o = KIND_TILE;
      end
    endcase
  end

  assign frame_done_o = (slot == SLOT_TILE) & head.done;

`ifndef NO_ASSERTIONS
  // The credit check on input must keep the event queue from overflowing.
  a_evq_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |-> (cnt_q < (EVQ_AW + 1)'(EVQ_DEPTH)))
    else $error("event queue overflow");

  // The first byte of a frame always starts a fresh tile accumulator.
  a_hdr_seeds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (b_valid_q && b_hdr_q) |-> b_seed_q)
    else $error("frame header without accumulator seed");

  // A configuration write that hits a register restarts the frame.
  a_cfg_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_restart |=> (!started_q && (tile_col_q == '0) && (row_q == '0)))
    else $error("configuration write did not restart the frame");

  // End of frame is flagged only on a tile hash word.
  a_done_on_tile: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && frame_done_o) |-> (word_kind_o == KIND_TILE))
    else $error("frame_done on a non-hash word");
`endif

endmodule

### tb/tiled_frame_fnv_signature_core_tb.sv
`timescale 1ns / 100ps

module tiled_frame_fnv_signature_core_tb;
  import tffs_pkg::*;

  // Block geometry, kept at the defaults of the core.
  localparam int unsigned MAX_W     = 4096;
  localparam int unsigned TILE      = 64;
  localparam int unsigned TILE_COLS = (MAX_W + TILE - 1) / TILE;

  // Register index past the end of the map; the core must ignore it.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  // Cycles that the core may still spend on a byte after the last word
  // arrived, before a register write is allowed.
  localparam int unsigned SETTLE     = 10;
  localparam int unsigned RAND_BYTES = 32;
  localparam int unsigned FRAME_CAP  = 40;
  localparam int unsigned CYCLE_CAP  = 1000000;

  typedef struct packed {
    logic [31:0] word;
    word_kind_e  kind;
    logic        done;
  } word_t;

  typedef enum logic {ROW_BYTE, ROW_REG} row_kind_e;

  // One row of the directed table. For a register row, idx and data give the
  // write; for a byte row, data[7:0] is the byte. Where typed is set, the
  // header that this byte opens is written out by hand in hdr_w and hdr_h.
  typedef struct packed {
    row_kind_e             kind;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
    logic                  typed;
    logic [DIM_W-1:0]      hdr_w;
    logic [DIM_W-1:0]      hdr_h;
  } dir_row_t;

  localparam int unsigned DIR_LEN = 25;

  // The directed part: the reset geometry, an ignored write in the middle of
  // a frame, width and height of zero, the packed and planar formats at one
  // pixel, and saturating and exact maximum dimensions.
  dir_row_t dir_rows [DIR_LEN] = '{
    '{ROW_BYTE, REG_UNUSED,       13'h0000, 1'b1, 13'd64,   13'd64},
    '{ROW_BYTE, REG_UNUSED,       13'h00ff, 1'b0, 13'd0,    13'd0},
    '{ROW_REG,  REG_UNUSED,       13'h1fff, 1'b0, 13'd0,    13'd0},
    '{ROW_BYTE, REG_UNUSED,       13'h00a5, 1'b0, 13'd0,    13'd0},
    '{ROW_REG,  REG_FRAME_WIDTH,  13'h0000, 1'b0, 13'd0,    13'd0},
    '{ROW_REG,  REG_FRAME_HEIGHT, 13'h0000, 1'b0, 13'd0,    13'd0},
    '{ROW_REG,  REG_PIXEL_FORMAT, 13'h0000, 1'b0, 13'd0,    13'd0},
    '{ROW_BYTE, REG_UNUSED,       13'h0000, 1'b1, 13'd1,    13'd1},
    '{ROW_BYTE, REG_UNUSED,       13'h00ff, 1'b0, 13'd0,    13'd0},
    '{ROW_BYTE, REG_UNUSED,       13'h0080, 1'b0, 13'd0,    13'd0},
    '{ROW_BYTE, REG_UNUSED,       13'h0001, 1'b0, 13'd0,    13'd0},
    '{ROW_BYTE, REG_UNUSED,       13'h003c, 1'b1, 13'd1,    13'd1},
    '{ROW_REG,  REG_PIXEL_FORMAT, 13'h1fff, 1'b0, 13'd0,    13'd0},
    '{ROW_BYTE, REG_UNUSED,       13'h0000, 1'b1, 13'd1,    13'd1},
    '{ROW_BYTE, REG_UNUSED,       13'h00ff, 1'b0, 13'd0,    13'd0},
    '{ROW_REG,  REG_FRAME_WIDTH,  13'h1fff, 1'b0, 13'd0,    13'd0},
    '{ROW_REG,  REG_FRAME_HEIGHT, 13'h1fff, 1'b0, 13'd0,    13'd0},
    '{ROW_BYTE, REG_UNUSED,       13'h007e, 1'b1, 13'd4096, 13'd4096},
    '{ROW_REG,  REG_FRAME_WIDTH,  13'h1000, 1'b0, 13'd0,    13'd0},
    '{ROW_REG,  REG_FRAME_HEIGHT, 13'h1000, 1'b0, 13'd0,    13'd0},
    '{ROW_BYTE, REG_UNUSED,       13'h00c3, 1'b1, 13'd4096, 13'd4096},
    '{ROW_REG,  REG_FRAME_WIDTH,  13'h0001, 1'b0, 13'd0,    13'd0},
    '{ROW_REG,  REG_FRAME_HEIGHT, 13'h0001, 1'b0, 13'd0,    13'd0},
    '{ROW_BYTE, REG_UNUSED,       13'h0055, 1'b1, 13'd1,    13'd1},
    '{ROW_BYTE, REG_UNUSED,       13'h0099, 1'b0, 13'd0,    13'd0}
  };

  logic                  clk_i        = 1'b0;
  logic                  rst_ni       = 1'b0;
  logic                  cfg_valid_i  = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i  = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i   = '0;
  logic                  in_valid_i   = 1'b0;
  logic                  in_ready_o;
  logic [7:0]            pixel_byte_i = '0;
  logic                  out_valid_o;
  logic                  out_ready_i  = 1'b0;
  logic [31:0]           out_word_o;
  logic [1:0]            word_kind_o;
  logic                  frame_done_o;

  tiled_frame_fnv_signature_core #(
    .MAX_WIDTH(MAX_W),
    .TILE_SIZE(TILE)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .pixel_byte_i(pixel_byte_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o),
    .word_kind_o (word_kind_o),
    .frame_done_o(frame_done_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Words that the core owes us, oldest first.
  word_t       words_due [$];
  logic [7:0]  bytes_to_send [$];
  int unsigned fail_count  = 0;
  int unsigned cycle_count = 0;
  // Set by the stimulus; when high, the byte sender offers back to back.
  bit          burst       = 1'b0;
  // A long output stall requested by the stimulus, served by the receiver.
  int unsigned hold_cycles = 0;

  // Shadow of the core: registers, one accumulator per tile column, and the
  // position of the next byte within the frame.
  logic [DIM_W-1:0]  shadow_w   = 13'd64;
  logic [DIM_W-1:0]  shadow_h   = 13'd64;
  logic              shadow_fmt = 1'b0;
  logic [31:0]       col_acc [TILE_COLS];
  logic [1:0]        byte_pos   = '0;
  logic [11:0]       px_col     = '0;
  logic [12:0]       row_cnt    = '0;
  logic              in_frame   = 1'b0;

  // Hand-typed header dimensions for the next frame start, if any.
  bit                hdr_typed  = 1'b0;
  logic [DIM_W-1:0]  typed_w, typed_h;

  function automatic int unsigned eff_width();
    if (shadow_w < 1) return 1;
    if (shadow_w > MAX_W) return MAX_W;
    return 32'(shadow_w);
  endfunction

  function automatic int unsigned eff_height();
    if (shadow_h < 1) return 1;
    if (shadow_h > HEIGHT_LIMIT) return HEIGHT_LIMIT;
    return 32'(shadow_h);
  endfunction

  // Planar frames carry half as many chroma rows again, rounded up.
  function automatic int unsigned frame_rows();
    int unsigned h;
    h = eff_height();
    return shadow_fmt ? h + (h + 1) / 2 : h;
  endfunction

  function automatic int unsigned frame_bytes();
    return eff_width() * (shadow_fmt ? 1 : 4) * frame_rows();
  endfunction

  function automatic void owe_word(input logic [31:0] word, input word_kind_e kind,
                                   input logic done);
    word_t item;
    item      = '{word: word, kind: kind, done: done};
    words_due = {words_due, item};
  endfunction

  // Any register write restarts the frame; an index past the map is dropped.
  function automatic void shadow_write(input logic [CFG_IDX_W-1:0] idx,
                                       input logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_FRAME_WIDTH:  shadow_w = data;
      REG_FRAME_HEIGHT: shadow_h = data;
      REG_PIXEL_FORMAT: shadow_fmt = data[0];
      default: return;
    endcase
    byte_pos = '0;
    px_col   = '0;
    row_cnt  = '0;
    in_frame = 1'b0;
  endfunction

  // Folds one accepted byte into its tile accumulator and queues the words
  // that it causes: the header on a frame start, a hash at the end of a tile.
  function automatic void hash_step(input logic [7:0] b);
    int unsigned w, bpp, rows, tcol, band_row;
    logic [31:0] acc;
    logic        last_col, last_row;
    w        = eff_width();
    bpp      = shadow_fmt ? 1 : 4;
    rows     = frame_rows();
    tcol     = px_col / TILE;
    band_row = row_cnt % TILE;
    if (!in_frame) begin
      owe_word(MAGIC_WORD0, KIND_MAGIC, 1'b0);
      owe_word(MAGIC_WORD1, KIND_MAGIC, 1'b0);
      owe_word(hdr_typed ? 32'(typed_w) : 32'(w), KIND_DIM, 1'b0);
      owe_word(hdr_typed ? 32'(typed_h) : 32'(eff_height()), KIND_DIM, 1'b0);
      hdr_typed = 1'b0;
      in_frame  = 1'b1;
    end
    // Each column accumulator is seeded at the first byte of its tile in
    // every band of rows.
    if (band_row == 0 && px_col % TILE == 0 && byte_pos == 0)
      col_acc[tcol] = FNV_BASIS;
    acc           = (col_acc[tcol] ^ {24'd0, b}) * FNV_PRIME;
    col_acc[tcol] = acc;
    last_col      = (px_col + 1 >= w);
    last_row      = (row_cnt + 1 >= rows);
    if (byte_pos + 1 >= bpp && (px_col % TILE == TILE - 1 || last_col) &&
        (band_row == TILE - 1 || last_row))
      owe_word(acc, KIND_TILE, last_col && last_row);
    if (byte_pos + 1 >= bpp) begin
      byte_pos = '0;
      if (last_col) begin
        px_col = '0;
        if (last_row) begin
          row_cnt  = '0;
          in_frame = 1'b0;
        end else begin
          row_cnt++;
        end
      end else begin
        px_col++;
      end
    end else begin
      byte_pos++;
    end
  endfunction

  // Register writes wait until the core has delivered everything and had
  // time to finish a byte that causes no word.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    bit fire;
    while (words_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    // Ready is sampled mid-cycle, where it is stable; the transfer itself
    // happens at the following rising edge.
    do begin
      @(negedge clk_i);
      fire = cfg_ready_o;
      if (fire) shadow_write(idx, data);
      @(posedge clk_i);
    end while (!fire);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Sends every queued byte. Valid drops only ahead of a gap, so back-to-back
  // bytes keep it high across the edge.
  task automatic stream_bytes();
    int unsigned gap;
    bit          fire;
    while (bytes_to_send.size() != 0) begin
      gap = burst ? 0 : $urandom_range(0, 13);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      in_valid_i   <= 1'b1;
      pixel_byte_i <= bytes_to_send[0];
      // The expectation is queued before the transfer edge, so the receiver
      // always finds it, however short the latency of the core.
      do begin
        @(negedge clk_i);
        fire = in_ready_o;
        if (fire) hash_step(bytes_to_send[0]);
        @(posedge clk_i);
      end while (!fire);
      void'(bytes_to_send.pop_front());
    end
    in_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic queue_random_bytes(input int unsigned n);
    repeat (n) bytes_to_send = {bytes_to_send, 8'($urandom_range(0, 255))};
  endtask

  // Dimensions: mostly a few pixels, sometimes around one tile, sometimes
  // zero or anything up to the full field, which saturates.
  function automatic logic [DIM_W-1:0] pick_dim();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return DIM_W'($urandom_range(63, 65));
      2:       return DIM_W'($urandom_range(7, 8191));
      default: return DIM_W'($urandom_range(1, 6));
    endcase
  endfunction

  // Output side: draws a stall before each word, with calm stretches where
  // it takes every word at once, and serves the long hold when asked.
  initial begin : receive_words
    int unsigned gap, calm_left;
    bit          calm, got;
    logic [31:0] word;
    logic [1:0]  kind;
    logic        done;
    word_t       due;
    calm_left = 0;
    calm      = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_cycles > 0) begin
        out_ready_i <= 1'b0;
        repeat (hold_cycles) @(posedge clk_i);
        hold_cycles = 0;
      end
      if (calm_left == 0) begin
        calm      = ($urandom_range(0, 3) == 0);
        calm_left = $urandom_range(10, 60);
      end
      calm_left--;
      gap = calm ? 0 : $urandom_range(0, 13);
      if (gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do begin
        @(negedge clk_i);
        got  = out_valid_o;
        word = out_word_o;
        kind = word_kind_o;
        done = frame_done_o;
        @(posedge clk_i);
      end while (!got);
      if (words_due.size() == 0) begin
        $error("unexpected word %08h (kind %0d, frame_done %0b)", word, kind, done);
        fail_count++;
      end else begin
        due = words_due.pop_front();
        if (due.word !== word) begin
          $error("out_word: expected %08h, got %08h", due.word, word);
          fail_count++;
        end
        if (due.kind !== kind) begin
          $error("word_kind: expected %0d, got %0d", due.kind, kind);
          fail_count++;
        end
        if (due.done !== done) begin
          $error("frame_done: expected %0b, got %0b", due.done, done);
          fail_count++;
        end
      end
    end
  end

  // Hard stop in case the core hangs or loses words.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_CAP) begin
      $display("tiled_frame_fnv_signature_core regression: fail");
      $finish;
    end
  end

  initial begin : run_stimulus
    int unsigned rand_sent, nframes, n;
    logic [2:0]  pick;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table.
    for (int i = 0; i < DIR_LEN; i++) begin
      if (dir_rows[i].kind == ROW_REG) begin
        write_reg(dir_rows[i].idx, dir_rows[i].data);
      end else begin
        if (dir_rows[i].typed) begin
          hdr_typed = 1'b1;
          typed_w   = dir_rows[i].hdr_w;
          typed_h   = dir_rows[i].hdr_h;
        end
        bytes_to_send = {bytes_to_send, dir_rows[i].data[7:0]};
        stream_bytes();
      end
    end

    // Full-width packed row: the first tile of the row closes at byte 256.
    write_reg(REG_FRAME_WIDTH, 13'd4096);
    write_reg(REG_PIXEL_FORMAT, 13'd0);
    queue_random_bytes(256);
    stream_bytes();

    // One-pixel planar frames of two bytes: every byte causes words, the four-word
    // header at each frame start and a tile hash at each frame end. The receiver
    // stalls for a long stretch while bytes keep coming back to back, so the result
    // queue fills and the core must hold off its input.
    write_reg(REG_FRAME_WIDTH, 13'd1);
    write_reg(REG_FRAME_HEIGHT, 13'd1);
    write_reg(REG_PIXEL_FORMAT, 13'd1);
    burst       = 1'b1;
    hold_cycles = 400;
    queue_random_bytes(16);
    stream_bytes();

    // Random phases: a fresh setting, then mostly whole frames; the last
    // frame of a phase is sometimes cut short and abandoned by the next
    // write, and frames too long for the run are always cut short.
    rand_sent = 0;
    while (rand_sent < RAND_BYTES) begin
      pick = 3'($urandom_range(1, 7));
      if (pick[0]) write_reg(REG_FRAME_WIDTH, pick_dim());
      if (pick[1]) write_reg(REG_FRAME_HEIGHT, pick_dim());
      if (pick[2]) write_reg(REG_PIXEL_FORMAT, CFG_DATA_W'($urandom_range(0, 8191)));
      if ($urandom_range(0, 7) == 0)
        write_reg(REG_UNUSED, CFG_DATA_W'($urandom_range(0, 8191)));
      burst   = ($urandom_range(0, 3) == 0);
      nframes = $urandom_range(1, 3);
      for (int f = 0; f < nframes; f++) begin
        n = frame_bytes();
        if (n > FRAME_CAP) begin
          n = $urandom_range(1, FRAME_CAP);
          f = nframes;
        end else if (f == nframes - 1 && $urandom_range(0, 3) == 0) begin
          n = $urandom_range(1, n);
        end
        queue_random_bytes(n);
        rand_sent += n;
        stream_bytes();
      end
    end

    // Drain, then leave room for any stray word to show up.
    while (words_due.size() != 0) @(posedge clk_i);
    repeat (4 * SETTLE) @(posedge clk_i);
    if (fail_count == 0)
      $display("tiled_frame_fnv_signature_core regression: pass");
    else
      $display("tiled_frame_fnv_signature_core regression: fail");
    $finish;
  end

endmodule
